// ===== hdl/pljh_pkg.sv =====
// Shared definitions for the per-label joint histogram core.
// Field widths, opcodes, controller state encoding, command/status bundles.
// No dependencies.
package pljh_pkg;

    localparam int LABEL_W = 16;
    localparam int SLOT_W  = 5;
    localparam int BIN_W   = 7;
    localparam int COUNT_W = 32;
    localparam int LIU_W   = 6;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADDR  = 5'b00100,
        S_READ  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    typedef struct packed {
        logic clr_we;
        logic load;
        logic resolve;
        logic rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/per_label_joint_histogram_core.sv =====
// Per-label joint histogram core: counts voxels into a BINS x BINS histogram of two
// quantized channels for each nonzero label, slots assigned in first-seen order, counters
// saturating; a read transfer returns one cell of one slot with the slot's label. After
// reset the counter store is swept to zero, one entry per cycle, over all
// MAX_LABELS*BINS*BINS entries (326432 with the defaults) while the input is stalled.
// Each transfer then passes through slot lookup and address, a registered read of the
// counter memory, and the write-back on its single port before the next is accepted.
// The result sits in an output register; the write-back of the following transfer holds
// until that register is free. Uses pljh_pkg, pljh_ctrl and pljh_datapath.
module per_label_joint_histogram_core #(
    parameter int MAX_LABELS = 32,
    parameter int BINS       = 101
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [pljh_pkg::LABEL_W-1:0]      i_label,
    input  logic [pljh_pkg::SLOT_W-1:0]       i_slot,
    input  logic [pljh_pkg::BIN_W-1:0]        i_bin_a,
    input  logic [pljh_pkg::BIN_W-1:0]        i_bin_b,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pljh_pkg::COUNT_W-1:0]      o_count,
    output logic [pljh_pkg::LABEL_W-1:0]      o_slot_label,
    output logic                              o_hit,
    output logic                              o_dropped,
    output logic [pljh_pkg::LIU_W-1:0]        o_labels_in_use
);

    localparam logic [pljh_pkg::LIU_W-1:0] FULL_LIU = MAX_LABELS[pljh_pkg::LIU_W-1:0];

    pljh_pkg::t_cmd  cmd;
    pljh_pkg::t_stat stat;

    pljh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pljh_datapath #(
        .MAX_LABELS (MAX_LABELS),
        .BINS       (BINS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_label         (i_label),
        .i_slot          (i_slot),
        .i_bin_a         (i_bin_a),
        .i_bin_b         (i_bin_b),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_count         (o_count),
        .o_slot_label    (o_slot_label),
        .o_hit           (o_hit),
        .o_dropped       (o_dropped),
        .o_labels_in_use (o_labels_in_use)
    );

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed over a waiting result");

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transfer accepted while one is in flight");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (!o_hit && o_labels_in_use == FULL_LIU))
        else $error("drop reported with free slots or with a hit");

endmodule

// ===== hdl/pljh_ctrl.sv =====
// Sequencer for the per-label joint histogram core.
// Runs the clearing sweep after reset, then steps each transfer through address, counter read and write-back.
// Depends on pljh_pkg.
module pljh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pljh_pkg::t_stat  i_stat,
    output pljh_pkg::t_cmd   o_cmd
);

    pljh_pkg::t_state r_state;
    pljh_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pljh_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = pljh_pkg::S_IDLE;
                end
            end
            pljh_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pljh_pkg::S_ADDR;
                end
            end
            pljh_pkg::S_ADDR: begin
                o_cmd.resolve = 1'b1;
                n_state       = pljh_pkg::S_READ;
            end
            pljh_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = pljh_pkg::S_WRITE;
            end
            pljh_pkg::S_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = pljh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pljh_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pljh_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != pljh_pkg::S_IDLE);

endmodule

// ===== hdl/pljh_datapath.sv =====
// Datapath of the per-label joint histogram core: label slot table,
// counter store with clearing sweep, saturating update and result register.
// Depends on pljh_pkg; driven by pljh_ctrl.
module pljh_datapath #(
    parameter int MAX_LABELS = 32,
    parameter int BINS       = 101
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pljh_pkg::t_cmd                    i_cmd,
    output pljh_pkg::t_stat                   o_stat,
    input  logic                              i_opcode,
    input  logic [pljh_pkg::LABEL_W-1:0]      i_label,
    input  logic [pljh_pkg::SLOT_W-1:0]       i_slot,
    input  logic [pljh_pkg::BIN_W-1:0]        i_bin_a,
    input  logic [pljh_pkg::BIN_W-1:0]        i_bin_b,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [pljh_pkg::COUNT_W-1:0]      o_count,
    output logic [pljh_pkg::LABEL_W-1:0]      o_slot_label,
    output logic                              o_hit,
    output logic                              o_dropped,
    output logic [pljh_pkg::LIU_W-1:0]        o_labels_in_use
);

    localparam int SW    = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int CW    = $clog2(MAX_LABELS + 1);
    localparam int BW    = $clog2(BINS);
    localparam int PW    = $clog2(BINS * BINS);
    localparam int DEPTH = MAX_LABELS * BINS * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = (CW > pljh_pkg::SLOT_W) ? CW : pljh_pkg::SLOT_W;

    function automatic logic [BW-1:0] clamp_bin(input logic [pljh_pkg::BIN_W-1:0] v);
        logic [8:0] w;
        w = 9'(v);
        if (w >= 9'(BINS)) begin
            return BW'(BINS - 1);
        end
        return BW'(v);
    endfunction

    logic                          r_op;
    logic [pljh_pkg::LABEL_W-1:0]  r_label;
    logic [pljh_pkg::SLOT_W-1:0]   r_slot;
    logic [PW-1:0]                 r_ab;
    logic [MAX_LABELS-1:0]         r_match;
    logic [pljh_pkg::LABEL_W-1:0]  r_labels [MAX_LABELS];
    logic [CW-1:0]                 r_used;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_clr;
    logic                          r_hit;
    logic                          r_drop;
    logic [pljh_pkg::LABEL_W-1:0]  r_slot_label;
    logic [pljh_pkg::COUNT_W-1:0]  mem [DEPTH];
    logic [pljh_pkg::COUNT_W-1:0]  r_rdata;
    logic                          r_out_valid;
    logic [pljh_pkg::COUNT_W-1:0]  r_o_count;
    logic [pljh_pkg::LABEL_W-1:0]  r_o_slot_label;
    logic                          r_o_hit;
    logic                          r_o_dropped;
    logic [pljh_pkg::LIU_W-1:0]    r_o_liu;

    logic [PW-1:0]                 n_ab;
    logic [MAX_LABELS-1:0]         n_match;
    logic [SW-1:0]                 enc;
    logic                          any_match;
    logic                          rd_hit;
    logic                          table_full;
    logic                          n_hit;
    logic                          n_drop;
    logic                          ins;
    logic [SW-1:0]                 n_sel;
    logic [pljh_pkg::LABEL_W-1:0]  n_lab;
    logic [AW-1:0]                 n_addr;
    logic [pljh_pkg::COUNT_W-1:0]  n_cnt;
    logic                          wb_en;

    assign n_ab = PW'(clamp_bin(i_bin_a)) * PW'(BINS) + PW'(clamp_bin(i_bin_b));

    always_comb begin
        for (int i = 0; i < MAX_LABELS; i++) begin
            n_match[i] = (CW'(i) < r_used) && (r_labels[i] == i_label);
        end
    end

    always_comb begin
        enc = '0;
        for (int i = 0; i < MAX_LABELS; i++) begin
            if (r_match[i]) begin
                enc = enc | SW'(i);
            end
        end
    end

    assign any_match  = |r_match;
    assign rd_hit     = (EW'(r_slot) < EW'(r_used));
    assign table_full = (r_used == CW'(MAX_LABELS));

    always_comb begin
        n_hit  = 1'b0;
        n_drop = 1'b0;
        ins    = 1'b0;
        n_sel  = '0;
        n_lab  = '0;
        if (r_op == pljh_pkg::OP_READ) begin
            if (rd_hit) begin
                n_hit = 1'b1;
                n_sel = SW'(r_slot);
                n_lab = r_labels[SW'(r_slot)];
            end
        end else if (r_label != '0) begin
            if (any_match) begin
                n_hit = 1'b1;
                n_sel = enc;
                n_lab = r_label;
            end else if (!table_full) begin
                n_hit = 1'b1;
                ins   = 1'b1;
                n_sel = SW'(r_used);
                n_lab = r_label;
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    assign n_addr = AW'(n_sel) * AW'(BINS * BINS) + AW'(r_ab);
    assign n_cnt  = (r_rdata == '1) ? r_rdata : r_rdata + pljh_pkg::COUNT_W'(1);
    assign wb_en  = i_cmd.commit && r_hit && (r_op == pljh_pkg::OP_ACCUM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_label <= i_label;
            r_slot  <= i_slot;
            r_ab    <= n_ab;
            r_match <= n_match;
        end
        if (i_cmd.resolve) begin
            r_addr       <= n_addr;
            r_hit        <= n_hit;
            r_drop       <= n_drop;
            r_slot_label <= n_lab;
            if (ins) begin
                r_labels[n_sel] <= r_label;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.resolve && ins) begin
            r_used <= r_used + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            mem[r_clr] <= '0;
        end else if (wb_en) begin
            mem[r_addr] <= n_cnt;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (!r_hit) begin
                r_o_count <= '0;
            end else if (r_op == pljh_pkg::OP_ACCUM) begin
                r_o_count <= n_cnt;
            end else begin
                r_o_count <= r_rdata;
            end
            r_o_slot_label <= r_slot_label;
            r_o_hit        <= r_hit;
            r_o_dropped    <= r_drop;
            r_o_liu        <= pljh_pkg::LIU_W'(r_used);
        end
    end

    assign o_stat.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_count         = r_o_count;
    assign o_slot_label    = r_o_slot_label;
    assign o_hit           = r_o_hit;
    assign o_dropped       = r_o_dropped;
    assign o_labels_in_use = r_o_liu;

endmodule

// ===== bench/per_label_joint_histogram_core_tb.sv =====
// Self-checking bench for per_label_joint_histogram_core: directed and random voxel/read
// transfers, predicted per transfer and compared field by field on the result port.
// Depends on pljh_pkg and the core RTL.
module per_label_joint_histogram_core_tb;

    localparam int MAX_LABELS  = 32;
    localparam int BINS        = 101;
    localparam int POOL_SIZE   = 40;
    localparam int PHASE_A     = 450;
    localparam int PHASE_B     = 380;
    localparam int PHASE_C     = 120;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT     = 600;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic                          op;
        logic [pljh_pkg::LABEL_W-1:0]  label;
        logic [pljh_pkg::SLOT_W-1:0]   slot;
        logic [pljh_pkg::BIN_W-1:0]    bin_a;
        logic [pljh_pkg::BIN_W-1:0]    bin_b;
        bit                            pause;
        bit                            quiet;
    } t_hist_req;

    typedef struct packed {
        logic [pljh_pkg::COUNT_W-1:0]  count;
        logic [pljh_pkg::LABEL_W-1:0]  slot_label;
        logic                          hit;
        logic                          dropped;
        logic [pljh_pkg::LIU_W-1:0]    labels_in_use;
    } t_hist_resp;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_opcode = pljh_pkg::OP_ACCUM;
    logic [pljh_pkg::LABEL_W-1:0]  i_label = '0;
    logic [pljh_pkg::SLOT_W-1:0]   i_slot = '0;
    logic [pljh_pkg::BIN_W-1:0]    i_bin_a = '0;
    logic [pljh_pkg::BIN_W-1:0]    i_bin_b = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [pljh_pkg::COUNT_W-1:0]  o_count;
    logic [pljh_pkg::LABEL_W-1:0]  o_slot_label;
    logic                          o_hit;
    logic                          o_dropped;
    logic [pljh_pkg::LIU_W-1:0]    o_labels_in_use;

    per_label_joint_histogram_core #(
        .MAX_LABELS(MAX_LABELS),
        .BINS      (BINS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_label        (i_label),
        .i_slot         (i_slot),
        .i_bin_a        (i_bin_a),
        .i_bin_b        (i_bin_b),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_count        (o_count),
        .o_slot_label   (o_slot_label),
        .o_hit          (o_hit),
        .o_dropped      (o_dropped),
        .o_labels_in_use(o_labels_in_use)
    );

    logic [pljh_pkg::LABEL_W-1:0]  slot_owner [MAX_LABELS];
    int                            owners_used;
    logic [pljh_pkg::COUNT_W-1:0]  cell_count [int];

    t_hist_req                     pending_reqs [$];
    t_hist_resp                    expected_results [$];
    logic [pljh_pkg::LABEL_W-1:0]  label_pool [POOL_SIZE];

    t_hist_req           cur_req;
    int                  gap_left;
    int                  stall_left;
    int                  results_seen;
    int                  quiet_after;
    bit                  long_hold_done;
    int                  errors;
    int                  cycles;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_bin(logic [pljh_pkg::BIN_W-1:0] v);
        return (v >= BINS) ? BINS - 1 : int'(v);
    endfunction

    function automatic t_hist_resp histogram_update(t_hist_req r);
        t_hist_resp res;
        int a;
        int b;
        int s;
        int k;
        bit found;
        res = '0;
        a = clamp_bin(r.bin_a);
        b = clamp_bin(r.bin_b);
        found = 1'b0;
        if (r.op == pljh_pkg::OP_READ) begin
            s = int'(r.slot);
            if (s < owners_used) begin
                k = (s * BINS + a) * BINS + b;
                res.count = cell_count.exists(k) ? cell_count[k] : '0;
                res.slot_label = slot_owner[s];
                res.hit = 1'b1;
            end
        end else if (r.label != '0) begin
            for (s = 0; s < owners_used; s++) begin
                if (slot_owner[s] == r.label) begin
                    found = 1'b1;
                    break;
                end
            end
            if (!found) begin
                if (owners_used < MAX_LABELS) begin
                    s = owners_used;
                    slot_owner[s] = r.label;
                    owners_used++;
                    found = 1'b1;
                end else begin
                    res.dropped = 1'b1;
                end
            end
            if (found) begin
                k = (s * BINS + a) * BINS + b;
                if (!cell_count.exists(k))
                    cell_count[k] = '0;
                if (cell_count[k] != '1)
                    cell_count[k] = cell_count[k] + 1;
                res.count = cell_count[k];
                res.slot_label = r.label;
                res.hit = 1'b1;
            end
        end
        res.labels_in_use = owners_used[pljh_pkg::LIU_W-1:0];
        return res;
    endfunction

    function automatic t_hist_req make_req(logic op, logic [pljh_pkg::LABEL_W-1:0] label,
                                           logic [pljh_pkg::SLOT_W-1:0] slot,
                                           logic [pljh_pkg::BIN_W-1:0] bin_a,
                                           logic [pljh_pkg::BIN_W-1:0] bin_b);
        t_hist_req r;
        r.op = op;
        r.label = label;
        r.slot = slot;
        r.bin_a = bin_a;
        r.bin_b = bin_b;
        r.pause = 1'b0;
        r.quiet = 1'b0;
        return r;
    endfunction

    function automatic logic [pljh_pkg::BIN_W-1:0] random_bin();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return pljh_pkg::BIN_W'($urandom_range(0, 2));
        else if (pick < 9)
            return pljh_pkg::BIN_W'($urandom_range(0, BINS - 1));
        return pljh_pkg::BIN_W'($urandom_range(BINS, 127));
    endfunction

    function automatic t_hist_req random_req(int pool_used);
        t_hist_req r;
        r = make_req(pljh_pkg::OP_ACCUM, pljh_pkg::LABEL_W'($urandom()),
                     pljh_pkg::SLOT_W'($urandom_range(0, 31)),
                     random_bin(), random_bin());
        if ($urandom_range(0, 9) < 3)
            r.op = pljh_pkg::OP_READ;
        else if ($urandom_range(0, 11) == 0)
            r.label = '0;
        else
            r.label = label_pool[$urandom_range(0, pool_used - 1)];
        return r;
    endfunction

    initial begin
        t_hist_req r;
        int i;
        int j;
        bit fresh;
        for (i = 0; i < MAX_LABELS; i++)
            slot_owner[i] = '0;
        owners_used = 0;
        errors = 0;

        label_pool[0] = 16'hFFFF;
        label_pool[1] = 16'h0001;
        label_pool[2] = 16'hAAAA;
        label_pool[3] = 16'h5555;
        for (i = 4; i < POOL_SIZE; i++) begin
            do begin
                label_pool[i] = pljh_pkg::LABEL_W'($urandom_range(1, 16'hFFFF));
                fresh = 1'b1;
                for (j = 0; j < i; j++)
                    if (label_pool[j] == label_pool[i])
                        fresh = 1'b0;
            end while (!fresh);
        end

        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd0,  7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'hFFFF, 5'd31, 7'd127, 7'd127));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'h0000, 5'd0,  7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'hFFFF, 5'd0,  7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'h0001, 5'd31, 7'd100, 7'd100));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'h0001, 5'd0,  7'd127, 7'd127));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'h0001, 5'd0,  7'd101, 7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'hFFFF, 5'd31, 7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'hAAAA, 5'd21, 7'd127, 7'd100));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'h5555, 5'd10, 7'd55,  7'd42));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd0,  7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd1,  7'd127, 7'd127));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd1,  7'd100, 7'd101));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'hFFFF, 5'd2,  7'd100, 7'd100));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd3,  7'd55,  7'd42));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd4,  7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd31, 7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'h0000, 5'd31, 7'd127, 7'd127));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'hFFFF, 5'd0,  7'd0,   7'd0));
        pending_reqs.push_back(make_req(pljh_pkg::OP_ACCUM, 16'h0001, 5'd31, 7'd1,   7'd1));
        pending_reqs.push_back(make_req(pljh_pkg::OP_READ,  16'h0000, 5'd1,  7'd1,   7'd1));

        for (i = 0; i < PHASE_A; i++)
            pending_reqs.push_back(random_req(24));
        for (i = 0; i < PHASE_B; i++) begin
            r = random_req(POOL_SIZE);
            r.pause = (i == 0);
            pending_reqs.push_back(r);
        end
        for (i = 0; i < PHASE_C; i++) begin
            r = random_req(POOL_SIZE);
            r.quiet = 1'b1;
            pending_reqs.push_back(r);
        end
        quiet_after = pending_reqs.size() - PHASE_C;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        bit offer;
        if (i_rst_n) begin
            offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(histogram_update(cur_req));
                offer = 1'b0;
                if (!cur_req.quiet && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 13);
            end
            if (!offer) begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].pause && expected_results.size() != 0)) begin
                    cur_req = pending_reqs.pop_front();
                    offer = 1'b1;
                end
            end
            i_in_valid <= offer;
            i_opcode   <= cur_req.op;
            i_label    <= cur_req.label;
            i_slot     <= cur_req.slot;
            i_bin_a    <= cur_req.bin_a;
            i_bin_b    <= cur_req.bin_b;
        end
    end

    always @(posedge i_clk) begin
        t_hist_resp want;
        bit hold;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result count %0d label %0h", $realtime,
                             o_count, o_slot_label);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d", $realtime,
                                 want.count, o_count);
                        errors++;
                    end
                    if (o_slot_label !== want.slot_label) begin
                        $display("%0t: slot_label expected %0h actual %0h", $realtime,
                                 want.slot_label, o_slot_label);
                        errors++;
                    end
                    if (o_hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $realtime,
                                 want.hit, o_hit);
                        errors++;
                    end
                    if (o_dropped !== want.dropped) begin
                        $display("%0t: dropped expected %0b actual %0b", $realtime,
                                 want.dropped, o_dropped);
                        errors++;
                    end
                    if (o_labels_in_use !== want.labels_in_use) begin
                        $display("%0t: labels_in_use expected %0d actual %0d", $realtime,
                                 want.labels_in_use, o_labels_in_use);
                        errors++;
                    end
                end
                results_seen++;
            end
            if (!long_hold_done && results_seen == HOLD_AT) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end
            hold = 1'b0;
            if (stall_left > 0) begin
                stall_left--;
                hold = 1'b1;
            end else if (results_seen < quiet_after && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                hold = 1'b1;
            end
            i_out_stall <= hold;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// ===== per_label_joint_histogram_core.f =====
hdl/pljh_pkg.sv
hdl/pljh_ctrl.sv
hdl/pljh_datapath.sv
hdl/per_label_joint_histogram_core.sv
bench/per_label_joint_histogram_core_tb.sv
